[sv/rvid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvid_pkg
// Opcodes, mnemonic codes, status codes and field widths of the RV64I
// subset decoder.
// ----------------------------------------------------------------------------
package rvid_pkg;

    localparam int WORD_W   = 32;
    localparam int NUM_W    = 16;
    localparam int MNEM_W   = 6;
    localparam int STAT_W   = 2;
    localparam int REG_W    = 5;
    localparam int IMM_W    = 21;
    localparam int TGT_W    = 20;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    localparam logic [6:0] OPC_R      = 7'b0110011;
    localparam logic [6:0] OPC_IALU   = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] F7_BASE    = 7'b0000000;
    localparam logic [6:0] F7_ALT     = 7'b0100000;
    localparam logic [5:0] F6_BASE    = 6'b000000;
    localparam logic [5:0] F6_ALT     = 6'b010000;

    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;

    localparam logic [MNEM_W-1:0] MN_ADD  = 6'd0;
    localparam logic [MNEM_W-1:0] MN_SUB  = 6'd1;
    localparam logic [MNEM_W-1:0] MN_XOR  = 6'd2;
    localparam logic [MNEM_W-1:0] MN_OR   = 6'd3;
    localparam logic [MNEM_W-1:0] MN_AND  = 6'd4;
    localparam logic [MNEM_W-1:0] MN_SLL  = 6'd5;
    localparam logic [MNEM_W-1:0] MN_SRL  = 6'd6;
    localparam logic [MNEM_W-1:0] MN_SRA  = 6'd7;
    localparam logic [MNEM_W-1:0] MN_ADDI = 6'd8;
    localparam logic [MNEM_W-1:0] MN_XORI = 6'd9;
    localparam logic [MNEM_W-1:0] MN_ORI  = 6'd10;
    localparam logic [MNEM_W-1:0] MN_ANDI = 6'd11;
    localparam logic [MNEM_W-1:0] MN_SLLI = 6'd12;
    localparam logic [MNEM_W-1:0] MN_SRLI = 6'd13;
    localparam logic [MNEM_W-1:0] MN_SRAI = 6'd14;
    localparam logic [MNEM_W-1:0] MN_LB   = 6'd15;
    localparam logic [MNEM_W-1:0] MN_SB   = 6'd22;
    localparam logic [MNEM_W-1:0] MN_BEQ  = 6'd26;
    localparam logic [MNEM_W-1:0] MN_BNE  = 6'd27;
    localparam logic [MNEM_W-1:0] MN_BLT  = 6'd28;
    localparam logic [MNEM_W-1:0] MN_BGE  = 6'd29;
    localparam logic [MNEM_W-1:0] MN_BLTU = 6'd30;
    localparam logic [MNEM_W-1:0] MN_BGEU = 6'd31;
    localparam logic [MNEM_W-1:0] MN_JAL  = 6'd32;
    localparam logic [MNEM_W-1:0] MN_JALR = 6'd33;
    localparam logic [MNEM_W-1:0] MN_LUI  = 6'd34;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_BOUNDS  = 2'd2;

endpackage

[sv/riscv_instruction_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riscv_instruction_decoder
// Decodes one RV64I subset word per cycle (unless stalled) into mnemonic,
// registers, immediate and status, with a branch/jal target bounds check.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  instr_word, instr_number
//  m_axis    out  m_axis_tvalid/m_axis_tready  mnemonic, status, regs, imm
//  cfg       in   cfg_we                       program_count
//
//  One item per cycle unless m_axis stalls; input register, result register.
//  The decode and the bounds add/compare sit between the two registers.
//  Reset clears the valid flags and program_count.
//  A stalled result holds; the input register can still fill while the
//  result register waits, so a stall stops intake only once both are full.
// ----------------------------------------------------------------------------
module riscv_instruction_decoder
    import rvid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [NUM_W-1:0]     cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [31:0] instr_word, [47:32] instr_number
    input  logic [S_DATA_W-1:0]  s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [5:0] mnemonic, [7:6] status, [12:8] dest_reg, [17:13] src1_reg,
    // [22:18] src2_reg, [43:23] immediate, [47:44] zero
    output logic [M_DATA_W-1:0]  m_axis_tdata
);

    logic [NUM_W-1:0]         prog_count_reg;
    logic                     in_valid_reg;
    logic [WORD_W-1:0]        in_word_reg;
    logic [NUM_W-1:0]         in_num_reg;
    logic                     out_valid_reg;
    logic [M_DATA_W-1:0]      out_data_reg;
    logic [M_DATA_W-1:0]      out_data_next;
    logic                     out_load;
    logic                     in_load;

    logic [6:0]               opc;
    logic [2:0]               f3;
    logic [6:0]               f7;
    logic [5:0]               hi6;
    logic [REG_W-1:0]         rd;
    logic [REG_W-1:0]         rs1;
    logic [REG_W-1:0]         rs2;
    logic signed [IMM_W-1:0]  imm_i;
    logic signed [IMM_W-1:0]  imm_s;
    logic signed [IMM_W-1:0]  imm_b;
    logic signed [IMM_W-1:0]  imm_j;
    logic signed [IMM_W-1:0]  imm_sh;
    logic signed [IMM_W-1:0]  imm_u;

    logic [MNEM_W-1:0]        mn;
    logic [STAT_W-1:0]        st;
    logic [REG_W-1:0]         od;
    logic [REG_W-1:0]         o1;
    logic [REG_W-1:0]         o2;
    logic signed [IMM_W-1:0]  imm;
    logic                     bad;
    logic                     chk_tgt;
    logic signed [IMM_W-1:0]  imm_adj;
    logic signed [TGT_W-1:0]  target;
    logic                     tgt_bad;

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign opc = in_word_reg[6:0];
    assign rd  = in_word_reg[11:7];
    assign f3  = in_word_reg[14:12];
    assign rs1 = in_word_reg[19:15];
    assign rs2 = in_word_reg[24:20];
    assign f7  = in_word_reg[31:25];
    assign hi6 = in_word_reg[31:26];

    assign imm_i  = {{9{in_word_reg[31]}}, in_word_reg[31:20]};
    assign imm_s  = {{9{in_word_reg[31]}}, in_word_reg[31:25], in_word_reg[11:7]};
    assign imm_b  = {{8{in_word_reg[31]}}, in_word_reg[31], in_word_reg[7],
                     in_word_reg[30:25], in_word_reg[11:8], 1'b0};
    assign imm_j  = {in_word_reg[31], in_word_reg[19:12], in_word_reg[20],
                     in_word_reg[30:21], 1'b0};
    assign imm_sh = {15'd0, in_word_reg[25:20]};
    assign imm_u  = {1'b0, in_word_reg[31:12]};

    always_comb begin
        mn      = MN_ADD;
        od      = '0;
        o1      = '0;
        o2      = '0;
        imm     = '0;
        bad     = 1'b0;
        chk_tgt = 1'b0;
        case (opc)
            OPC_R: begin
                od = rd;
                o1 = rs1;
                o2 = rs2;
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_0:    mn = MN_ADD;
                        F3_1:    mn = MN_SLL;
                        F3_4:    mn = MN_XOR;
                        F3_5:    mn = MN_SRL;
                        F3_6:    mn = MN_OR;
                        F3_7:    mn = MN_AND;
                        default: bad = 1'b1;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_0) begin
                    mn = MN_SUB;
                end else if (f7 == F7_ALT && f3 == F3_5) begin
                    mn = MN_SRA;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_IALU: begin
                od  = rd;
                o1  = rs1;
                imm = imm_i;
                case (f3)
                    F3_0: mn = MN_ADDI;
                    F3_4: mn = MN_XORI;
                    F3_6: mn = MN_ORI;
                    F3_7: mn = MN_ANDI;
                    F3_1: begin
                        mn  = MN_SLLI;
                        imm = imm_sh;
                        bad = (hi6 != F6_BASE);
                    end
                    F3_5: begin
                        imm = imm_sh;
                        if (hi6 == F6_BASE) begin
                            mn = MN_SRLI;
                        end else if (hi6 == F6_ALT) begin
                            mn = MN_SRAI;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    default: bad = 1'b1;
                endcase
            end
            OPC_LOAD: begin
                od  = rd;
                o1  = rs1;
                imm = imm_i;
                mn  = MN_LB + {3'd0, f3};
                bad = (f3 == F3_7);
            end
            OPC_STORE: begin
                o1  = rs1;
                o2  = rs2;
                imm = imm_s;
                mn  = MN_SB + {3'd0, f3};
                bad = f3[2];
            end
            OPC_BRANCH: begin
                o1      = rs1;
                o2      = rs2;
                imm     = imm_b;
                chk_tgt = 1'b1;
                case (f3)
                    F3_0:    mn = MN_BEQ;
                    F3_1:    mn = MN_BNE;
                    F3_4:    mn = MN_BLT;
                    F3_5:    mn = MN_BGE;
                    F3_6:    mn = MN_BLTU;
                    F3_7:    mn = MN_BGEU;
                    default: bad = 1'b1;
                endcase
            end
            OPC_JAL: begin
                od      = rd;
                mn      = MN_JAL;
                imm     = imm_j;
                chk_tgt = 1'b1;
            end
            OPC_JALR: begin
                od  = rd;
                o1  = rs1;
                mn  = MN_JALR;
                imm = imm_i;
            end
            OPC_LUI: begin
                od  = rd;
                mn  = MN_LUI;
                imm = imm_u;
            end
            default: bad = 1'b1;
        endcase
    end

    // target = number + imm/4, quotient truncated toward zero
    assign imm_adj = imm[IMM_W-1] ? (imm + 21'sd3) : imm;
    assign target  = $signed({4'd0, in_num_reg}) + TGT_W'(imm_adj >>> 2);
    assign tgt_bad = target[TGT_W-1] ||
                     (target[TGT_W-2:0] > {3'd0, prog_count_reg});

    always_comb begin
        if (bad) begin
            st = ST_INVALID;
        end else if (chk_tgt && tgt_bad) begin
            st = ST_BOUNDS;
        end else begin
            st = ST_OK;
        end
        if (bad) begin
            out_data_next = {4'd0, {IMM_W{1'b0}}, 15'd0, ST_INVALID, MN_ADD};
        end else begin
            out_data_next = {4'd0, imm, o2, o1, od, st, mn};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_count_reg <= '0;
        end else if (cfg_we) begin
            prog_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_word_reg <= s_axis_tdata[WORD_W-1:0];
            in_num_reg  <= s_axis_tdata[WORD_W+NUM_W-1:WORD_W];
        end
        if (out_load && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    a_invalid_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[7:6] == ST_INVALID)
        |-> (m_axis_tdata[5:0] == MN_ADD && m_axis_tdata[43:8] == '0))
        else $error("invalid item carries nonzero fields");

    a_bounds_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[7:6] == ST_BOUNDS)
        |-> (m_axis_tdata[5:0] >= MN_BEQ && m_axis_tdata[5:0] <= MN_JAL))
        else $error("bounds status on a non-branch item");

    a_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted item not held in input register");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_load) |=> out_valid_reg)
        else $error("decoded item lost between stages");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RV64I subset decoder. Instruction words are
// streamed in, bursty in some phases, while the result side stalls on a
// random pattern in some phases. Each accepted item is decoded by a local
// predictor, and each result is checked in order against it. The run repeats
// over several program_count settings, including both extremes and one long output hold.
// ----------------------------------------------------------------------------
module tb_top;
    import rvid_pkg::*;

    typedef struct packed {
        logic [MNEM_W-1:0]        mn;
        logic [STAT_W-1:0]        status;
        logic [REG_W-1:0]         rd;
        logic [REG_W-1:0]         rs1;
        logic [REG_W-1:0]         rs2;
        logic signed [IMM_W-1:0]  imm;
    } decode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [NUM_W-1:0]     cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;

    logic [S_DATA_W-1:0]  instr_q[$];
    decode_t              pending_decodes[$];
    logic [15:0]          pc_shadow = '0;

    bit          s_took = 1'b0;
    bit          gaps_on = 1'b0;
    bit          stall_on = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          hold_left = 0;
    logic [15:0] stall_pat = '1;
    logic [3:0]  pat_pos = '0;

    int n_sent = 0;
    int n_results = 0;
    int n_ok = 0;
    int n_invalid = 0;
    int n_bounds = 0;
    int n_settings = 0;
    int mismatches = 0;

    decode_t              got;
    decode_t              want;

    riscv_instruction_decoder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---- predictor ----------------------------------------------------------
    function automatic bit target_out(input logic [15:0] num,
                                      input logic signed [IMM_W-1:0] imm,
                                      input logic [15:0] pc);
        int target;
        target = int'(num) + int'(imm) / 4;
        return target > int'(pc) || target < 0;
    endfunction

    function automatic decode_t decode_word(input logic [31:0] w, input logic [15:0] num,
                                            input logic [15:0] pc);
        decode_t    d;
        logic [2:0] f3;
        logic [6:0] f7;
        bit         bad;
        d = '0;
        bad = 1'b0;
        f3 = w[14:12];
        f7 = w[31:25];
        case (w[6:0])
            OPC_R: begin
                d.rd = w[11:7];
                d.rs1 = w[19:15];
                d.rs2 = w[24:20];
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_0: d.mn = MN_ADD;
                        F3_1: d.mn = MN_SLL;
                        F3_4: d.mn = MN_XOR;
                        F3_5: d.mn = MN_SRL;
                        F3_6: d.mn = MN_OR;
                        F3_7: d.mn = MN_AND;
                        default: bad = 1'b1;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_0) begin
                    d.mn = MN_SUB;
                end else if (f7 == F7_ALT && f3 == F3_5) begin
                    d.mn = MN_SRA;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_IALU: begin
                d.rd = w[11:7];
                d.rs1 = w[19:15];
                d.imm = {{9{w[31]}}, w[31:20]};
                case (f3)
                    F3_0: d.mn = MN_ADDI;
                    F3_4: d.mn = MN_XORI;
                    F3_6: d.mn = MN_ORI;
                    F3_7: d.mn = MN_ANDI;
                    F3_1: begin
                        if (w[31:26] == F6_BASE) begin
                            d.mn = MN_SLLI;
                            d.imm = {15'd0, w[25:20]};
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    F3_5: begin
                        d.imm = {15'd0, w[25:20]};
                        if (w[31:26] == F6_BASE) d.mn = MN_SRLI;
                        else if (w[31:26] == F6_ALT) d.mn = MN_SRAI;
                        else bad = 1'b1;
                    end
                    default: bad = 1'b1;
                endcase
            end
            OPC_LOAD: begin
                d.rd = w[11:7];
                d.rs1 = w[19:15];
                d.imm = {{9{w[31]}}, w[31:20]};
                if (f3 == F3_7) bad = 1'b1;
                else d.mn = MN_LB + {3'd0, f3};
            end
            OPC_STORE: begin
                d.rs1 = w[19:15];
                d.rs2 = w[24:20];
                d.imm = {{9{w[31]}}, w[31:25], w[11:7]};
                if (f3 > F3_3) bad = 1'b1;
                else d.mn = MN_SB + {3'd0, f3};
            end
            OPC_BRANCH: begin
                d.rs1 = w[19:15];
                d.rs2 = w[24:20];
                d.imm = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                case (f3)
                    F3_0: d.mn = MN_BEQ;
                    F3_1: d.mn = MN_BNE;
                    F3_4: d.mn = MN_BLT;
                    F3_5: d.mn = MN_BGE;
                    F3_6: d.mn = MN_BLTU;
                    F3_7: d.mn = MN_BGEU;
                    default: bad = 1'b1;
                endcase
                if (!bad && target_out(num, d.imm, pc)) d.status = ST_BOUNDS;
            end
            OPC_JAL: begin
                d.rd = w[11:7];
                d.mn = MN_JAL;
                d.imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
                if (target_out(num, d.imm, pc)) d.status = ST_BOUNDS;
            end
            OPC_JALR: begin
                d.rd = w[11:7];
                d.rs1 = w[19:15];
                d.mn = MN_JALR;
                d.imm = {{9{w[31]}}, w[31:20]};
            end
            OPC_LUI: begin
                d.rd = w[11:7];
                d.mn = MN_LUI;
                d.imm = {1'b0, w[31:12]};
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            d = '0;
            d.status = ST_INVALID;
        end
        return d;
    endfunction

    // ---- encoders -----------------------------------------------------------
    function automatic logic [31:0] enc_branch(input logic [12:0] imm, input logic [2:0] f3,
                                               input logic [4:0] rs1, input logic [4:0] rs2);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_jal(input logic [20:0] imm, input logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    // ---- input side ---------------------------------------------------------
    always @(posedge aclk) begin
        s_took = aresetn && s_axis_tvalid && s_axis_tready;
        if (s_took) begin
            pending_decodes.insert(pending_decodes.size(),
                                   decode_word(s_axis_tdata[31:0], s_axis_tdata[47:32],
                                               pc_shadow));
            void'(instr_q.pop_front());
            n_sent++;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_took) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (instr_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= instr_q[0];
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = (gaps_on && $urandom_range(0, 2) == 0) ?
                               $urandom_range(1, 10) : 0;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---- result side --------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!stall_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (pat_pos == 0)
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'($urandom & $urandom) :
                                                          16'($urandom | $urandom);
            m_axis_tready <= stall_pat[pat_pos];
            pat_pos++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            got.mn = m_axis_tdata[5:0];
            got.status = m_axis_tdata[7:6];
            got.rd = m_axis_tdata[12:8];
            got.rs1 = m_axis_tdata[17:13];
            got.rs2 = m_axis_tdata[22:18];
            got.imm = m_axis_tdata[43:23];
            if (pending_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t: mn=%0d st=%0d", $realtime,
                             got.mn, got.status);
            end else begin
                want = pending_decodes.pop_front();
                case (want.status)
                    ST_OK:      n_ok++;
                    ST_INVALID: n_invalid++;
                    default:    n_bounds++;
                endcase
                if (got !== want || m_axis_tdata[47:44] !== 4'd0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t (result %0d, pc %0d)", $realtime,
                                 n_results, pc_shadow);
                        $display("  exp mn=%0d st=%0d rd=%0d rs1=%0d rs2=%0d imm=%0d",
                                 want.mn, want.status, want.rd, want.rs1, want.rs2, want.imm);
                        $display("  got mn=%0d st=%0d rd=%0d rs1=%0d rs2=%0d imm=%0d pad=%h",
                                 got.mn, got.status, got.rd, got.rs1, got.rs2, got.imm,
                                 m_axis_tdata[47:44]);
                    end
                end
            end
        end
    end

    // ---- stimulus -----------------------------------------------------------
    task automatic push_item(input logic [31:0] w, input logic [15:0] num);
        instr_q.insert(instr_q.size(), {num, w});
    endtask

    task automatic write_program_count(input logic [15:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        pc_shadow = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic wait_drained();
        while (instr_q.size() != 0 || pending_decodes.size() != 0 || s_axis_tvalid)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic gen_item(input logic [15:0] pc, output logic [31:0] w,
                            output logic [15:0] num);
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [11:0] imm12;
        logic [12:0] imm13;
        logic [20:0] imm21;
        int          pick;
        int          off;
        int          k;
        rd = 5'($urandom);
        rs1 = 5'($urandom);
        rs2 = 5'($urandom);
        f3 = 3'($urandom);
        imm12 = 12'($urandom);
        off = $urandom_range(0, 6);
        k = $urandom_range(0, 40);
        k = k - 20;
        case ($urandom_range(0, 3))
            0: num = 16'(off);
            1: num = (pc > off) ? 16'(int'(pc) - off) : 16'd0;
            2: num = 16'($urandom_range(0, pc));
            default: num = 16'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            if ($urandom_range(0, 7) == 0) f7 = 7'($urandom);
            else f7 = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
            w = {f7, rs2, rs1, f3, rd, OPC_R};
        end else if (pick < 26) begin
            w = {imm12, rs1, f3, rd, OPC_IALU};
            if (f3 == F3_1 || f3 == F3_5) begin
                case ($urandom_range(0, 5))
                    0: ;
                    1, 2: w[31:26] = F6_ALT;
                    default: w[31:26] = F6_BASE;
                endcase
            end
        end else if (pick < 36) begin
            w = {imm12, rs1, f3, rd, OPC_LOAD};
        end else if (pick < 46) begin
            w = {imm12[11:5], rs2, rs1, f3, imm12[4:0], OPC_STORE};
        end else if (pick < 64) begin
            if ($urandom_range(0, 3) == 0) imm13 = 13'($urandom);
            else imm13 = 13'(2 * k);
            w = enc_branch(imm13, f3, rs1, rs2);
        end else if (pick < 76) begin
            if ($urandom_range(0, 3) == 0) imm21 = 21'($urandom);
            else imm21 = 21'(2 * k);
            w = enc_jal(imm21, rd);
        end else if (pick < 83) begin
            w = {imm12, rs1, f3, rd, OPC_JALR};
        end else if (pick < 90) begin
            w = $urandom;
            w[11:0] = {rd, OPC_LUI};
        end else begin
            w = $urandom;
        end
    endtask

    task automatic run_phase(input logic [15:0] pc, input int n, input bit gaps,
                             input bit stalls, input int hold);
        logic [31:0] w;
        logic [15:0] num;
        write_program_count(pc);
        @(negedge aclk);
        gaps_on = gaps;
        stall_on = stalls;
        hold_left = hold;
        for (int i = 0; i < n; i++) begin
            gen_item(pc, w, num);
            push_item(w, num);
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: every format, field extremes, invalid encodings, bound edges
        write_program_count(16'd10);
        @(negedge aclk);
        gaps_on = 1'b1;
        stall_on = 1'b1;
        push_item({F7_BASE, 5'd3, 5'd2, F3_0, 5'd1, OPC_R}, 16'd1);
        push_item({F7_ALT, 5'd31, 5'd31, F3_0, 5'd31, OPC_R}, 16'd2);
        push_item({F7_ALT, 5'd0, 5'd17, F3_5, 5'd9, OPC_R}, 16'd3);
        push_item({7'h01, 5'd4, 5'd5, F3_0, 5'd6, OPC_R}, 16'd4);
        push_item({F7_BASE, 5'd1, 5'd1, F3_2, 5'd1, OPC_R}, 16'd5);
        push_item({12'h800, 5'd31, F3_0, 5'd31, OPC_IALU}, 16'd6);
        push_item({12'h7FF, 5'd0, F3_7, 5'd0, OPC_IALU}, 16'd7);
        push_item({F6_BASE, 6'd63, 5'd7, F3_1, 5'd8, OPC_IALU}, 16'd8);
        push_item({F6_ALT, 6'd1, 5'd2, F3_5, 5'd3, OPC_IALU}, 16'd9);
        push_item({6'b000001, 6'd5, 5'd2, F3_5, 5'd3, OPC_IALU}, 16'd9);
        push_item({12'h123, 5'd2, F3_2, 5'd3, OPC_IALU}, 16'd9);
        push_item({12'hFFF, 5'd10, F3_3, 5'd11, OPC_LOAD}, 16'd1);
        push_item({12'h004, 5'd10, F3_7, 5'd11, OPC_LOAD}, 16'd1);
        push_item({7'h40, 5'd21, 5'd22, F3_3, 5'd0, OPC_STORE}, 16'd1);
        push_item({7'h3F, 5'd21, 5'd22, F3_4, 5'h1F, OPC_STORE}, 16'd1);
        push_item(enc_branch(-13'sd4, F3_0, 5'd1, 5'd2), 16'd1);
        push_item(enc_branch(-13'sd8, F3_1, 5'd1, 5'd2), 16'd1);
        push_item(enc_branch(13'd0, F3_7, 5'd31, 5'd0), 16'd10);
        push_item(enc_branch(13'd4, F3_4, 5'd0, 5'd31), 16'd10);
        push_item(enc_branch(-13'sd6, F3_6, 5'd3, 5'd4), 16'd1);
        push_item(enc_branch(13'd4, F3_2, 5'd3, 5'd4), 16'd1);
        push_item(enc_jal(-21'sd2, 5'd1), 16'd0);
        push_item(enc_jal(21'h0FFFFE, 5'd31), 16'hFFFF);
        push_item(enc_jal(21'h100000, 5'd0), 16'd3);
        push_item({12'hABC, 5'd4, F3_7, 5'd5, OPC_JALR}, 16'd2);
        push_item({20'hFFFFF, 5'd30, OPC_LUI}, 16'd2);
        push_item(32'hFFFF_FFFF, 16'hFFFF);
        wait_drained();

        run_phase(16'hFFFF, 250, 1'b1, 1'b1, 0);
        run_phase(16'd0, 200, 1'b0, 1'b0, 0);
        run_phase(16'd1, 200, 1'b0, 1'b1, 300);   // long output hold, input keeps offering
        run_phase(16'($urandom_range(2, 65534)), 300, 1'b1, 1'b1, 0);
        run_phase(16'd24, 275, 1'b1, 1'b0, 0);

        repeat (8) @(negedge aclk);
        $display("%0d items over %0d program_count settings, %0d mismatches", n_sent,
                 n_settings, mismatches);
        $display("results: %0d decoded, %0d invalid, %0d target out of bounds", n_ok,
                 n_invalid, n_bounds);
        if (mismatches == 0 && pending_decodes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout: %0d items queued, %0d results outstanding", instr_q.size(),
                 pending_decodes.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
